[hdl/pagt_pkg.sv]
// Shared types, constants and the arctangent table of the gravity torque block.
// No dependencies; every other file imports this package.
`default_nettype none
package pagt_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_N = 24;
	localparam int N_CELLS = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
	localparam int SHIFT_W = 5;

	localparam int ANGLE_W = 16;
	localparam int SUM_W = ANGLE_W + 2;
	localparam int RED_W = SUM_W + 1;
	localparam int Z_W = 33;
	localparam int XY_W = 33;
	localparam int TRIG_W = 32;
	localparam int COEF_W = 32;
	localparam int PROD_W = COEF_W + TRIG_W;
	localparam int FRAC_SHIFT = 30;
	localparam int TERM_W = PROD_W - FRAC_SHIFT;
	localparam int ACC_W = TERM_W + 2;
	localparam int TORQUE_W = 32;
	localparam int Z_SHIFT = 18;

	localparam int PI_Q12 = 12868;
	localparam int HALF_PI_Q12 = 6434;
	localparam int TWO_PI_Q12 = 25736;
	localparam int N_WRAP = 4;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

	localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_N] = '{
		33'h03243F6A8, 33'h01DAC6705, 33'h00FADBAFC, 33'h007F56EA6,
		33'h003FEAB76, 33'h001FFD55B, 33'h000FFFAAA, 33'h0007FFF55,
		33'h0003FFFEA, 33'h0001FFFFD, 33'h0000FFFFF, 33'h00007FFFF,
		33'h00003FFFF, 33'h00001FFFF, 33'h00000FFFF, 33'h000007FFF,
		33'h000003FFF, 33'h000001FFF, 33'h000000FFF, 33'h0000007FF,
		33'h0000003FF, 33'h0000001FF, 33'h0000000FF, 33'h00000007F
	};

	typedef logic [1:0] phase_t;
	localparam phase_t PH_COS = 2'd0;
	localparam phase_t PH_S12 = 2'd1;
	localparam phase_t PH_S123 = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 2'd3;

	typedef struct packed {
		logic   vld;
		phase_t phase;
		logic   neg_cos;
	} ctl_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_1;
		logic signed [ANGLE_W-1:0] angle_2;
		logic signed [ANGLE_W-1:0] angle_3;
	} angles_t;

	typedef struct packed {
		logic signed [TORQUE_W-1:0] torque_1;
		logic signed [TORQUE_W-1:0] torque_2;
		logic signed [TORQUE_W-1:0] torque_3;
	} torques_t;

endpackage
`default_nettype wire

[hdl/pagt_front.sv]
// Input holding register, angle sums, range reduction and fold into CORDIC start values.
// Depends on pagt_pkg.
`default_nettype none
module pagt_front import pagt_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   angle_valid,
	output logic                        angle_ready,
	input  wire angles_t                angles,
	input  wire logic                   adv,
	output ctl_t                        ctl_out,
	output logic signed [XY_W-1:0]      x_out,
	output logic signed [XY_W-1:0]      y_out,
	output logic signed [Z_W-1:0]       z_out
);

	logic                     feed_valid_q;
	phase_t                   phase_q;
	angles_t                  angles_q;
	logic signed [SUM_W-1:0]  sum_next;
	ctl_t                     ctl_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [RED_W-1:0]  cand [2*N_WRAP+1];
	logic signed [RED_W-1:0]  red;
	logic signed [RED_W-1:0]  folded;
	logic                     neg_cos;
	ctl_t                     ctl_s2;
	logic signed [Z_W-1:0]    z_s2;

	localparam logic signed [RED_W-1:0] PI_R = RED_W'(PI_Q12);
	localparam logic signed [RED_W-1:0] HALF_PI_R = RED_W'(HALF_PI_Q12);

	assign angle_ready = !feed_valid_q || (adv && phase_q == PH_S123);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_valid_q <= 1'b0;
			phase_q <= PH_COS;
		end else if (angle_valid && angle_ready) begin
			feed_valid_q <= 1'b1;
			phase_q <= PH_COS;
		end else if (adv && feed_valid_q) begin
			if (phase_q == PH_S123) begin
				feed_valid_q <= 1'b0;
			end else begin
				phase_q <= phase_t'(phase_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (angle_valid && angle_ready) begin
			angles_q <= angles;
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_COS:  sum_next = SUM_W'(angles_q.angle_1);
			PH_S12:  sum_next = SUM_W'(angles_q.angle_1) + SUM_W'(angles_q.angle_2);
			PH_S123: sum_next = SUM_W'(angles_q.angle_1) + SUM_W'(angles_q.angle_2)
				+ SUM_W'(angles_q.angle_3);
			default: sum_next = SUM_W'(angles_q.angle_1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{vld: feed_valid_q, phase: phase_q, neg_cos: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= sum_next;
		end
	end

	// reduce into [-pi, pi], then fold into [-pi/2, pi/2]
	always_comb begin
		for (int k = 0; k <= 2 * N_WRAP; k++) begin
			cand[k] = RED_W'(sum_s1) - RED_W'((k - N_WRAP) * TWO_PI_Q12);
		end
		red = cand[N_WRAP];
		for (int k = 2 * N_WRAP; k >= 0; k--) begin
			if (cand[k] >= -PI_R && cand[k] <= PI_R) begin
				red = cand[k];
			end
		end
		if (red > HALF_PI_R) begin
			folded = PI_R - red;
			neg_cos = 1'b1;
		end else if (red < -HALF_PI_R) begin
			folded = -PI_R - red;
			neg_cos = 1'b1;
		end else begin
			folded = red;
			neg_cos = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= '{vld: ctl_s1.vld, phase: ctl_s1.phase, neg_cos: neg_cos};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s2 <= Z_W'(folded) <<< Z_SHIFT;
		end
	end

	assign ctl_out = ctl_s2;
	assign x_out = CORDIC_GAIN;
	assign y_out = '0;
	assign z_out = z_s2;

endmodule
`default_nettype wire

[hdl/pagt_cell.sv]
// One CORDIC rotation cell: rotates (x, y) by one table angle toward z = 0.
// Depends on pagt_pkg.
`default_nettype none
module pagt_cell import pagt_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   adv,
	input  wire logic [SHIFT_W-1:0]     shift,
	input  wire logic signed [Z_W-1:0]  atan,
	input  wire ctl_t                   ctl_in,
	input  wire logic signed [XY_W-1:0] x_in,
	input  wire logic signed [XY_W-1:0] y_in,
	input  wire logic signed [Z_W-1:0]  z_in,
	output ctl_t                        ctl_out,
	output logic signed [XY_W-1:0]      x_out,
	output logic signed [XY_W-1:0]      y_out,
	output logic signed [Z_W-1:0]       z_out
);

	ctl_t                   ctl_s1;
	logic signed [XY_W-1:0] x_s1;
	logic signed [XY_W-1:0] y_s1;
	logic signed [Z_W-1:0]  z_s1;
	logic signed [XY_W-1:0] x_sh;
	logic signed [XY_W-1:0] y_sh;

	assign x_sh = x_in >>> shift;
	assign y_sh = y_in >>> shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!z_in[Z_W-1]) begin
				x_s1 <= x_in - y_sh;
				y_s1 <= y_in + x_sh;
				z_s1 <= z_in - atan;
			end else begin
				x_s1 <= x_in + y_sh;
				y_s1 <= y_in - x_sh;
				z_s1 <= z_in + atan;
			end
		end
	end

	assign ctl_out = ctl_s1;
	assign x_out = x_s1;
	assign y_out = y_s1;
	assign z_out = z_s1;

endmodule
`default_nettype wire

[hdl/pagt_acc.sv]
// Trig select, shared coefficient multiplier, rounding, torque sums, saturation, output register.
// Depends on pagt_pkg.
`default_nettype none
module pagt_acc import pagt_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ctl_t                     ctl_in,
	input  wire logic signed [XY_W-1:0]   x_in,
	input  wire logic signed [XY_W-1:0]   y_in,
	input  wire logic                     comp_enable,
	input  wire logic signed [COEF_W-1:0] coef_a,
	input  wire logic signed [COEF_W-1:0] coef_b,
	input  wire logic signed [COEF_W-1:0] coef_c,
	output logic                          adv,
	output logic                          torque_valid,
	input  wire logic                     torque_ready,
	output torques_t                      torques
);

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2147483647);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(2147483647) - ACC_W'(1);

	ctl_t                     ctl_s1;
	logic signed [TRIG_W-1:0] trig_s1;
	logic signed [COEF_W-1:0] coef_s1;
	ctl_t                     ctl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PROD_W-1:0] rounded;
	ctl_t                     ctl_s3;
	logic signed [TERM_W-1:0] term_s3;
	logic signed [TERM_W-1:0] ta_q;
	logic signed [TERM_W-1:0] tb_q;
	logic signed [ACC_W-1:0]  sum_1;
	logic signed [ACC_W-1:0]  sum_2;
	logic signed [ACC_W-1:0]  sum_3;
	logic                     last_term;
	logic                     torque_valid_q;
	torques_t                 torques_q;

	function automatic logic signed [TORQUE_W-1:0] sat(input logic signed [ACC_W-1:0] v);
		logic signed [TORQUE_W-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[TORQUE_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[TORQUE_W-1:0];
		end else begin
			r = v[TORQUE_W-1:0];
		end
		return r;
	endfunction

	assign last_term = ctl_s3.vld && ctl_s3.phase == PH_S123;
	assign adv = !(torque_valid_q && !torque_ready && last_term);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (ctl_in.phase)
				PH_COS: begin
					trig_s1 <= ctl_in.neg_cos ? TRIG_W'(-x_in) : TRIG_W'(x_in);
					coef_s1 <= coef_a;
				end
				PH_S12: begin
					trig_s1 <= TRIG_W'(y_in);
					coef_s1 <= coef_b;
				end
				PH_S123: begin
					trig_s1 <= TRIG_W'(y_in);
					coef_s1 <= coef_c;
				end
				default: begin
					trig_s1 <= TRIG_W'(y_in);
					coef_s1 <= coef_c;
				end
			endcase
			prod_s2 <= PROD_W'(coef_s1) * PROD_W'(trig_s1);
			term_s3 <= rounded[PROD_W-1:FRAC_SHIFT];
		end
	end

	assign rounded = prod_s2 + ROUND_HALF;

	assign sum_3 = ACC_W'(term_s3);
	assign sum_2 = ACC_W'(tb_q) + sum_3;
	assign sum_1 = ACC_W'(ta_q) + sum_2;

	always_ff @(posedge clk) begin
		if (adv && ctl_s3.vld) begin
			if (ctl_s3.phase == PH_COS) begin
				ta_q <= term_s3;
			end
			if (ctl_s3.phase == PH_S12) begin
				tb_q <= term_s3;
			end
		end
		if (adv && last_term) begin
			if (comp_enable) begin
				torques_q <= '{torque_1: sat(sum_1), torque_2: sat(sum_2), torque_3: sat(sum_3)};
			end else begin
				torques_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_valid_q <= 1'b0;
		end else if (adv && last_term) begin
			torque_valid_q <= 1'b1;
		end else if (torque_ready) begin
			torque_valid_q <= 1'b0;
		end
	end

	assign torque_valid = torque_valid_q;
	assign torques = torques_q;

	a_last_term_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_term |=> torque_valid)
		else $error("last term did not produce an item");

	a_stall_only_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> torque_valid && !torque_ready)
		else $error("pipeline stalled without a blocked item");

	a_stall_holds_term: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.vld && !adv |=> ctl_s3.vld && $stable(term_s3))
		else $error("stalled term changed");

endmodule
`default_nettype wire

[hdl/planar_arm_gravity_torque.sv]
// The three angle sums of an item share one CORDIC cell row and one 32x32 multiplier,
// one sum per cycle while adv is high; a new item can be accepted as the last sum of the previous one advances.
// Reset: arst_n clears control and config registers (disabled, coefficients zero).
// Depends on pagt_pkg, pagt_front, pagt_cell, pagt_acc.
`default_nettype none
module planar_arm_gravity_torque import pagt_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 angle_valid,
	output logic                      angle_ready,
	input  wire angles_t              angles,
	output logic                      torque_valid,
	input  wire logic                 torque_ready,
	output torques_t                  torques,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [COEF_W-1:0]    cfg_data
);

	logic                     comp_enable_q;
	logic signed [COEF_W-1:0] coef_a_q;
	logic signed [COEF_W-1:0] coef_b_q;
	logic signed [COEF_W-1:0] coef_c_q;
	logic                     adv;
	ctl_t                     chain_ctl [N_CELLS+1];
	logic signed [XY_W-1:0]   chain_x [N_CELLS+1];
	logic signed [XY_W-1:0]   chain_y [N_CELLS+1];
	logic signed [Z_W-1:0]    chain_z [N_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_enable_q <= 1'b0;
			coef_a_q <= '0;
			coef_b_q <= '0;
			coef_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ENABLE: comp_enable_q <= cfg_data[0];
				REG_COEF_A: coef_a_q <= cfg_data;
				REG_COEF_B: coef_b_q <= cfg_data;
				REG_COEF_C: coef_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pagt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_ready (angle_ready),
		.angles      (angles),
		.adv         (adv),
		.ctl_out     (chain_ctl[0]),
		.x_out       (chain_x[0]),
		.y_out       (chain_y[0]),
		.z_out       (chain_z[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		pagt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.shift   (SHIFT_W'(i)),
			.atan    (ATAN_TAB[i]),
			.ctl_in  (chain_ctl[i]),
			.x_in    (chain_x[i]),
			.y_in    (chain_y[i]),
			.z_in    (chain_z[i]),
			.ctl_out (chain_ctl[i+1]),
			.x_out   (chain_x[i+1]),
			.y_out   (chain_y[i+1]),
			.z_out   (chain_z[i+1])
		);
	end

	pagt_acc u_acc (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_in       (chain_ctl[N_CELLS]),
		.x_in         (chain_x[N_CELLS]),
		.y_in         (chain_y[N_CELLS]),
		.comp_enable  (comp_enable_q),
		.coef_a       (coef_a_q),
		.coef_b       (coef_b_q),
		.coef_c       (coef_c_q),
		.adv          (adv),
		.torque_valid (torque_valid),
		.torque_ready (torque_ready),
		.torques      (torques)
	);

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for planar_arm_gravity_torque: drives angle items, predicts torques
// with a bit-accurate CORDIC model and checks each torque item in order.
// Depends on pagt_pkg and planar_arm_gravity_torque.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pagt_pkg::*;

	localparam longint GAIN_Q30 = 652032874;
	localparam longint PI_Q12_TB = 12868;
	localparam longint HALF_PI_Q12_TB = 6434;
	localparam longint TWO_PI_Q12_TB = 25736;
	localparam int N_ROT = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
	localparam int DRAIN_CYCLES = CORDIC_STAGES + 8 + 16;
	localparam longint ATAN_Q30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	logic                 clk;
	logic                 arst_n;
	logic                 angle_valid;
	logic                 angle_ready;
	angles_t              angles;
	logic                 torque_valid;
	logic                 torque_ready;
	torques_t             torques;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [COEF_W-1:0]    cfg_data;

	bit       gain_enable;
	longint   gain_a;
	longint   gain_b;
	longint   gain_c;
	torques_t pending_torques [$];
	int       n_mismatches = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       recv_hold_cycles = 0;

	planar_arm_gravity_torque i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.angle_valid  (angle_valid),
		.angle_ready  (angle_ready),
		.angles       (angles),
		.torque_valid (torque_valid),
		.torque_ready (torque_ready),
		.torques      (torques),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void cordic_trig(input longint ang, output longint cos_v,
			output longint sin_v);
		longint x;
		longint y;
		longint z;
		longint nx;
		bit     flip;
		x = GAIN_Q30;
		y = 0;
		flip = 1'b0;
		while (ang > PI_Q12_TB) ang -= TWO_PI_Q12_TB;
		while (ang < -PI_Q12_TB) ang += TWO_PI_Q12_TB;
		if (ang > HALF_PI_Q12_TB) begin
			ang = PI_Q12_TB - ang;
			flip = 1'b1;
		end else if (ang < -HALF_PI_Q12_TB) begin
			ang = -PI_Q12_TB - ang;
			flip = 1'b1;
		end
		z = ang * 262144;
		for (int i = 0; i < N_ROT; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_Q30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_Q30[i];
			end
			x = nx;
		end
		cos_v = flip ? -x : x;
		sin_v = y;
	endfunction

	function automatic longint scale_q30(input longint coef, input longint t);
		return (coef * t + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic [TORQUE_W-1:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic torques_t predict_torques(input angles_t a);
		longint   q1;
		longint   q2;
		longint   q3;
		longint   c1;
		longint   s1;
		longint   c12;
		longint   s12;
		longint   c123;
		longint   s123;
		longint   ta;
		longint   tb;
		longint   tc;
		torques_t t;
		t = '0;
		if (!gain_enable)
			return t;
		q1 = $signed(a.angle_1);
		q2 = $signed(a.angle_2);
		q3 = $signed(a.angle_3);
		cordic_trig(q1, c1, s1);
		cordic_trig(q1 + q2, c12, s12);
		cordic_trig(q1 + q2 + q3, c123, s123);
		ta = scale_q30(gain_a, c1);
		tb = scale_q30(gain_b, s12);
		tc = scale_q30(gain_c, s123);
		t.torque_1 = clamp32(ta + tb + tc);
		t.torque_2 = clamp32(tb + tc);
		t.torque_3 = clamp32(tc);
		return t;
	endfunction

	function automatic angles_t mk_angles(input int a1, input int a2, input int a3);
		angles_t r;
		r.angle_1 = 16'(a1);
		r.angle_2 = 16'(a2);
		r.angle_3 = 16'(a3);
		return r;
	endfunction

	function automatic logic [ANGLE_W-1:0] rand_angle();
		int base;
		case ($urandom_range(3))
			0, 1: return 16'($urandom());
			2: return 16'(int'($urandom_range(25736)) - 12868);
			default: begin
				case ($urandom_range(6))
					0: base = 12868;
					1: base = -12868;
					2: base = 6434;
					3: base = -6434;
					4: base = 32767;
					5: base = -32768;
					default: base = 0;
				endcase
				return 16'(base + int'($urandom_range(6)) - 3);
			end
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return 32'(int'($urandom_range(2097152)) - 1048576);
			default: return $urandom();
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $realtime, msg);
		n_mismatches++;
	endtask

	task automatic check_field(input string name, input logic [TORQUE_W-1:0] got,
			input logic [TORQUE_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ENABLE: gain_enable = val[0];
			REG_COEF_A: gain_a = longint'($signed(val));
			REG_COEF_B: gain_b = longint'($signed(val));
			REG_COEF_C: gain_c = longint'($signed(val));
		endcase
	endtask

	task automatic set_gains(input bit en, input logic [COEF_W-1:0] a,
			input logic [COEF_W-1:0] b, input logic [COEF_W-1:0] c);
		write_reg(REG_ENABLE, {31'b0, en});
		write_reg(REG_COEF_A, a);
		write_reg(REG_COEF_B, b);
		write_reg(REG_COEF_C, c);
	endtask

	task automatic send_angles(input angles_t a);
		while ($urandom_range(99) < send_idle_pct) begin
			angle_valid <= 1'b0;
			@(posedge clk);
		end
		angle_valid <= 1'b1;
		angles <= a;
		@(posedge clk);
		while (!angle_ready) @(posedge clk);
		pending_torques.push_back(predict_torques(a));
	endtask

	task automatic wait_drained();
		angle_valid <= 1'b0;
		while (pending_torques.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_angle_extremes();
		set_gains(1'b1, 32'h0001_8000, 32'h0000_C000, 32'hFFFD_C000);
		send_angles(mk_angles(0, 0, 0));
		send_angles(mk_angles(32767, 32767, 32767));
		send_angles(mk_angles(-32768, -32768, -32768));
		send_angles(mk_angles(32767, -32768, 32767));
		send_angles(mk_angles(12868, 0, 0));
		send_angles(mk_angles(-12868, 0, 0));
		send_angles(mk_angles(12869, -1, 1));
		send_angles(mk_angles(6434, 0, 0));
		send_angles(mk_angles(-6434, 0, 0));
		send_angles(mk_angles(6435, -6436, 6435));
		send_angles(mk_angles(25736, 25736, -25736));
		send_angles(mk_angles(0, 6434, 6434));
		send_angles(mk_angles(-1, -1, -1));
		wait_drained();
	endtask

	task automatic test_saturation();
		set_gains(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_angles(mk_angles(0, 6434, 0));
		send_angles(mk_angles(0, -6434, 0));
		wait_drained();
		set_gains(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_angles(mk_angles(0, 6434, 0));
		send_angles(mk_angles(12868, -6434, 0));
		send_angles(mk_angles(0, -6434, 0));
		wait_drained();
	endtask

	task automatic test_disable();
		set_gains(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		send_angles(mk_angles(0, 6434, 0));
		send_angles(mk_angles(32767, -32768, 12868));
		send_angles(mk_angles(rand_angle(), rand_angle(), rand_angle()));
		wait_drained();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (4) begin
			set_gains($urandom_range(7) != 0, rand_coef(), rand_coef(), rand_coef());
			repeat (50) send_angles(mk_angles(rand_angle(), rand_angle(), rand_angle()));
			wait_drained();
		end
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_gains(1'b1, rand_coef(), rand_coef(), rand_coef());
		recv_hold_cycles = 400;
		repeat (40) send_angles(mk_angles(rand_angle(), rand_angle(), rand_angle()));
		wait_drained();
	endtask

	initial begin
		torque_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (recv_hold_cycles > 0) begin
				recv_hold_cycles--;
				torque_ready <= 1'b0;
			end else begin
				torque_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		torques_t want;
		if (arst_n && torque_valid && torque_ready) begin
			if (pending_torques.size() == 0) begin
				report_mismatch($sformatf("unexpected torque item %h", torques));
			end else begin
				want = pending_torques.pop_front();
				check_field("torque_1", torques.torque_1, want.torque_1);
				check_field("torque_2", torques.torque_2, want.torque_2);
				check_field("torque_3", torques.torque_3, want.torque_3);
			end
		end
	end

	initial begin
		#200us;
		$display("[planar_arm_gravity_torque] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		angle_valid = 1'b0;
		angles = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_ENABLE;
		cfg_data = '0;
		gain_enable = 1'b0;
		gain_a = 0;
		gain_b = 0;
		gain_c = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_angle_extremes();
		test_saturation();
		test_disable();
		test_random_traffic(0, 0);
		test_random_traffic(81, 0);
		test_random_traffic(0, 81);
		test_random_traffic(7, 7);
		test_output_backpressure();
		if (n_mismatches == 0 && pending_torques.size() == 0) begin
			$display("[planar_arm_gravity_torque] OK");
		end else begin
			$display("[planar_arm_gravity_torque] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/pagt_pkg.sv
hdl/pagt_front.sv
hdl/pagt_cell.sv
hdl/pagt_acc.sv
hdl/planar_arm_gravity_torque.sv
tb/tb_top.sv
